>>> sv/lbps_pkg.sv
// ---------------------------------------------------------------------------
// LED blink pattern sequencer package
// Shared types, command codes, register indexes and reset values for the
// LED blink pattern sequencer and its channel step logic.
// ---------------------------------------------------------------------------
package lbps_pkg;

   // Default values for the top-level parameters.
   localparam int BLINK_STEPS_DEF = 4;
   localparam int LED_COUNT_DEF   = 3;

   // Channel arrangement: three LED channels and the group channel.
   localparam int         NUM_CHAN   = 4;
   localparam logic [1:0] GROUP_CHAN = 2'd3;
   localparam int         GROUP_IDX  = 3;
   localparam int         LED_PINS   = 3;

   // Command codes.
   localparam logic [3:0] CMD_TICK     = 4'd0;
   localparam logic [3:0] CMD_ON       = 4'd1;
   localparam logic [3:0] CMD_OFF      = 4'd2;
   localparam logic [3:0] CMD_SLOW     = 4'd3;
   localparam logic [3:0] CMD_FAST     = 4'd4;
   localparam logic [3:0] CMD_BREATHE  = 4'd5;
   localparam logic [3:0] CMD_DOUBLE   = 4'd6;
   localparam logic [3:0] CMD_ALL_ON   = 4'd7;
   localparam logic [3:0] CMD_ALL_OFF  = 4'd8;
   localparam logic [3:0] CMD_IDLE_OFF = 4'd9;

   // Configuration register indexes.
   localparam logic [3:0] CSR_SLOW_PERIOD    = 4'd0;
   localparam logic [3:0] CSR_FAST_PERIOD    = 4'd1;
   localparam logic [3:0] CSR_BREATHE_PERIOD = 4'd2;
   localparam logic [3:0] CSR_SHORT_GAP      = 4'd3;
   localparam logic [3:0] CSR_LONG_GAP       = 4'd4;
   localparam logic [3:0] CSR_SLOW_STEPS     = 4'd5;
   localparam logic [3:0] CSR_FAST_STEPS     = 4'd6;
   localparam logic [3:0] CSR_BREATHE_STEPS  = 4'd7;

   // Pattern modes of a channel.
   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_SLOW,
      MODE_FAST,
      MODE_BREATHE,
      MODE_DOUBLE
   } mode_type;

   // Input transaction payload.
   typedef struct packed {
      logic [3:0] command;
      logic [1:0] channel;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [2:0] led_lit;
      logic [3:0] running_mask;
      logic       rejected;
   } rsp_type;

   // State of one channel.
   typedef struct packed {
      mode_type    mode;
      logic [7:0]  count;
      logic [15:0] timer;
      logic [15:0] period;
      logic        running;
   } chan_type;

   // Configuration registers.
   typedef struct packed {
      logic [15:0] slow_period;
      logic [15:0] fast_period;
      logic [15:0] breathe_period;
      logic [15:0] short_gap;
      logic [15:0] long_gap;
      logic [7:0]  slow_steps;
      logic [7:0]  fast_steps;
      logic [7:0]  breathe_steps;
   } cfg_type;

   // Effect of one channel step on its LEDs.
   typedef struct packed {
      logic wr;
      logic lit;
   } led_fx_type;

   localparam chan_type CHAN_RESET = '{
      mode:    MODE_NONE,
      count:   8'd0,
      timer:   16'd0,
      period:  16'd0,
      running: 1'b0
   };

   localparam cfg_type CFG_RESET = '{
      slow_period:    16'd500,
      fast_period:    16'd100,
      breathe_period: 16'd200,
      short_gap:      16'd200,
      long_gap:       16'd1000,
      slow_steps:     8'd10,
      fast_steps:     8'd4,
      breathe_steps:  8'd6
   };

endpackage

>>> sv/lbps_chan_step.sv
// ---------------------------------------------------------------------------
// LED blink pattern sequencer channel step
// Next state of one channel on a base tick: timer countdown, reload, and the
// flash or double blink pattern step with its effect on the LEDs.
// ---------------------------------------------------------------------------
module lbps_chan_step #(
   parameter int BLINK_STEPS = lbps_pkg::BLINK_STEPS_DEF
) (
   input  lbps_pkg::cfg_type    cfg,
   input  lbps_pkg::chan_type   cur,
   output lbps_pkg::chan_type   nxt,
   output lbps_pkg::led_fx_type fx
);

   localparam logic [7:0] BLINK_CNT = 8'(BLINK_STEPS);

   always_comb begin
      logic [7:0] steps;
      logic [7:0] cnt;
      logic       flash;

      nxt   = cur;
      fx    = '0;
      steps = 8'd0;
      cnt   = cur.count;
      flash = 1'b0;

      // Pattern length of the flash modes.
      unique case (cur.mode)
         lbps_pkg::MODE_SLOW: begin
            steps = cfg.slow_steps;
            flash = 1'b1;
         end
         lbps_pkg::MODE_FAST: begin
            steps = cfg.fast_steps;
            flash = 1'b1;
         end
         lbps_pkg::MODE_BREATHE: begin
            steps = cfg.breathe_steps;
            flash = 1'b1;
         end
         default: begin
            steps = 8'd0;
            flash = 1'b0;
         end
      endcase

      if (cur.running) begin
         if (cur.timer > 16'd1) begin
            // Period not yet expired.
            nxt.timer = cur.timer - 16'd1;
         end else begin
            nxt.timer = cur.period;
            if (flash) begin
               // Lit for one step, dark for the remaining steps.
               if (cnt >= steps) begin
                  fx.wr  = 1'b1;
                  fx.lit = 1'b1;
                  cnt    = steps;
               end else if (cnt == steps - 8'd1) begin
                  fx.wr  = 1'b1;
                  fx.lit = 1'b0;
               end
               if (cnt != 8'd0) begin
                  cnt = cnt - 8'd1;
               end
               if (cnt == 8'd0) begin
                  cnt = steps;
               end
               nxt.count = cnt;
            end else if (cur.mode == lbps_pkg::MODE_DOUBLE) begin
               // Toggle on count parity, adjust the gap, stop at zero.
               if (cnt >= BLINK_CNT) begin
                  cnt = BLINK_CNT;
               end
               fx.wr  = 1'b1;
               fx.lit = ~cnt[0];
               if (cnt[1:0] == 2'd0) begin
                  nxt.period = cfg.long_gap;
               end else if (cnt[1:0] == 2'd1) begin
                  nxt.period = cfg.short_gap;
               end
               nxt.timer = nxt.period;
               if (cnt != 8'd0) begin
                  cnt = cnt - 8'd1;
               end
               nxt.count = cnt;
               if (cnt == 8'd0) begin
                  nxt.running = 1'b0;
               end
            end
         end
      end
   end

endmodule

>>> sv/led_blink_pattern_sequencer.sv
// A transaction passes the input register, then the result register, where it
// waits while the result side stalls. Throughput: one transaction per cycle
// unless the result side stalls. Ticks update all four channels and commands
// one or all channels in one pass of logic between the two registers.
// Reset is synchronous: channels stop, LEDs go dark, configuration registers take defaults.
// ---------------------------------------------------------------------------
// LED blink pattern sequencer
// Three LED channels and a group channel driven by ticks and commands, with
// flash and double blink patterns timed in base ticks.
// ---------------------------------------------------------------------------
module led_blink_pattern_sequencer #(
   parameter int BLINK_STEPS = lbps_pkg::BLINK_STEPS_DEF,
   parameter int LED_COUNT   = lbps_pkg::LED_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lbps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbps_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [3:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int NC = lbps_pkg::NUM_CHAN;

   lbps_pkg::cfg_type    cfg_ff;
   logic                 req_valid_ff;
   lbps_pkg::req_type    req_ff;
   lbps_pkg::chan_type   chan_ff [NC];
   lbps_pkg::chan_type   chan_in [NC];
   lbps_pkg::chan_type   tick_nxt [NC];
   lbps_pkg::led_fx_type tick_fx [NC];
   logic [LED_COUNT-1:0] led_ff;
   logic [LED_COUNT-1:0] led_in;
   logic                 rsp_valid_ff;
   lbps_pkg::rsp_type    rsp_ff;
   lbps_pkg::rsp_type    rsp_in;
   logic                 out_free;
   logic                 advance;

   function automatic lbps_pkg::chan_type cleared(lbps_pkg::chan_type c);
      lbps_pkg::chan_type r;
      r         = lbps_pkg::CHAN_RESET;
      r.period  = c.period;
      return r;
   endfunction

   function automatic lbps_pkg::chan_type started(lbps_pkg::mode_type mode,
                                                   logic [7:0] count,
                                                   logic [15:0] period);
      lbps_pkg::chan_type r;
      r.mode    = mode;
      r.count   = count;
      r.timer   = period;
      r.period  = period;
      r.running = 1'b1;
      return r;
   endfunction

   // Handshake: the result register frees when empty or taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Tick step of every channel in parallel.
   for (genvar g = 0; g < NC; g++) begin : g_chan
      lbps_chan_step #(
         .BLINK_STEPS(BLINK_STEPS)
      ) u_step (
         .cfg(cfg_ff),
         .cur(chan_ff[g]),
         .nxt(tick_nxt[g]),
         .fx (tick_fx[g])
      );
   end

   // Command decode and next state of channels and LEDs.
   always_comb begin
      logic [3:0] cmd;
      logic [1:0] ch;
      logic       chan_cmd;
      logic       ch_is_led;
      logic       rej;

      cmd       = req_ff.command;
      ch        = req_ff.channel;
      chan_cmd  = (cmd >= lbps_pkg::CMD_ON) && (cmd <= lbps_pkg::CMD_DOUBLE);
      ch_is_led = (ch != lbps_pkg::GROUP_CHAN) && (int'(ch) < LED_COUNT);
      rej       = 1'b0;
      led_in    = led_ff;
      for (int c = 0; c < NC; c++) begin
         chan_in[c] = chan_ff[c];
      end

      if (chan_cmd && (ch != lbps_pkg::GROUP_CHAN) && !ch_is_led) begin
         rej = 1'b1;
      end else begin
         unique case (cmd)
            lbps_pkg::CMD_TICK: begin
               for (int c = 0; c < NC; c++) begin
                  chan_in[c] = tick_nxt[c];
               end
               // LED channels first, the group has the last word.
               for (int i = 0; i < LED_COUNT; i++) begin
                  for (int c = 0; c < lbps_pkg::GROUP_IDX; c++) begin
                     if (c == i && tick_fx[c].wr) begin
                        led_in[i] = tick_fx[c].lit;
                     end
                  end
                  if (tick_fx[lbps_pkg::GROUP_IDX].wr) begin
                     led_in[i] = tick_fx[lbps_pkg::GROUP_IDX].lit;
                  end
               end
            end
            lbps_pkg::CMD_ON, lbps_pkg::CMD_OFF: begin
               if (ch == lbps_pkg::GROUP_CHAN) begin
                  rej = 1'b1;
               end else begin
                  chan_in[ch] = cleared(chan_ff[ch]);
                  for (int i = 0; i < LED_COUNT; i++) begin
                     if (int'(ch) == i) begin
                        led_in[i] = (cmd == lbps_pkg::CMD_ON);
                     end
                  end
               end
            end
            lbps_pkg::CMD_SLOW: begin
               chan_in[ch] = started(lbps_pkg::MODE_SLOW, cfg_ff.slow_steps,
                                     cfg_ff.slow_period);
            end
            lbps_pkg::CMD_FAST: begin
               chan_in[ch] = started(lbps_pkg::MODE_FAST, cfg_ff.fast_steps,
                                     cfg_ff.fast_period);
            end
            lbps_pkg::CMD_BREATHE: begin
               chan_in[ch] = started(lbps_pkg::MODE_BREATHE, cfg_ff.breathe_steps,
                                     cfg_ff.breathe_period);
            end
            lbps_pkg::CMD_DOUBLE: begin
               chan_in[ch] = started(lbps_pkg::MODE_DOUBLE, 8'(BLINK_STEPS),
                                     cfg_ff.short_gap);
            end
            lbps_pkg::CMD_ALL_ON, lbps_pkg::CMD_ALL_OFF: begin
               for (int c = 0; c < NC; c++) begin
                  chan_in[c] = cleared(chan_ff[c]);
               end
               led_in = {LED_COUNT{cmd == lbps_pkg::CMD_ALL_ON}};
            end
            lbps_pkg::CMD_IDLE_OFF: begin
               // Idle LED channels go dark; the group always stops.
               for (int c = 0; c < lbps_pkg::GROUP_IDX; c++) begin
                  if (c < LED_COUNT && !chan_ff[c].running) begin
                     chan_in[c] = cleared(chan_ff[c]);
                     for (int i = 0; i < LED_COUNT; i++) begin
                        if (c == i) begin
                           led_in[i] = 1'b0;
                        end
                     end
                  end
               end
               chan_in[lbps_pkg::GROUP_IDX] = cleared(chan_ff[lbps_pkg::GROUP_IDX]);
            end
            default: begin
               rej = 1'b0;
            end
         endcase
      end

      // Result fields from the updated state.
      rsp_in = '0;
      for (int i = 0; i < LED_COUNT; i++) begin
         for (int b = 0; b < lbps_pkg::LED_PINS; b++) begin
            if (b == i) begin
               rsp_in.led_lit[b] = led_in[i];
            end
         end
      end
      for (int c = 0; c < NC; c++) begin
         rsp_in.running_mask[c] = chan_in[c].running;
      end
      rsp_in.rejected = rej;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lbps_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lbps_pkg::CSR_SLOW_PERIOD:    cfg_ff.slow_period    <= csr_wdata;
            lbps_pkg::CSR_FAST_PERIOD:    cfg_ff.fast_period    <= csr_wdata;
            lbps_pkg::CSR_BREATHE_PERIOD: cfg_ff.breathe_period <= csr_wdata;
            lbps_pkg::CSR_SHORT_GAP:      cfg_ff.short_gap      <= csr_wdata;
            lbps_pkg::CSR_LONG_GAP:       cfg_ff.long_gap       <= csr_wdata;
            lbps_pkg::CSR_SLOW_STEPS:     cfg_ff.slow_steps     <= csr_wdata[7:0];
            lbps_pkg::CSR_FAST_STEPS:     cfg_ff.fast_steps     <= csr_wdata[7:0];
            lbps_pkg::CSR_BREATHE_STEPS:  cfg_ff.breathe_steps  <= csr_wdata[7:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_data;
      end
   end

   // Channel and LED state, committed as each transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            chan_ff[c] <= lbps_pkg::CHAN_RESET;
         end
         led_ff <= '0;
      end else if (advance) begin
         for (int c = 0; c < NC; c++) begin
            chan_ff[c] <= chan_in[c];
         end
         led_ff <= led_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> sv/lbps_checker.sv
// ---------------------------------------------------------------------------
// LED blink pattern sequencer checker
// Port-level assertions on handshake timing of the sequencer, bound to the
// top level.
// ---------------------------------------------------------------------------
module lbps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lbps_pkg::rsp_type rsp_data
);

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // After reset both registers are empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // The input side stalls only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // An accepted transaction gives a result if the result side is not stalled while it waits in the input register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("result transaction missing after accepted input");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
